// ===== design/tts_pkg.sv =====
// Shared types and constants of the tick task scheduler.
package tts_pkg;

   typedef enum logic [2:0] {
      MODE_TICK     = 3'd0,
      MODE_DISPATCH = 3'd1,
      MODE_ADD      = 3'd2,
      MODE_DELETE   = 3'd3,
      MODE_STOP     = 3'd4,
      MODE_RESUME   = 3'd5,
      MODE_STATUS   = 3'd6,
      MODE_COUNT    = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      ST_EMPTY    = 2'd0,
      ST_RUNNABLE = 2'd1,
      ST_STOPPED  = 2'd2,
      ST_UNKNOWN  = 2'd3
   } status_type;

   localparam int unsigned MAX_OUT = 8;

   localparam logic [1:0] REG_TICK_MS = 2'd0;
   localparam logic [1:0] REG_ENABLE  = 2'd1;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  task_id;
      logic [31:0] period_ms;
      logic [15:0] task_handle;
   } cmd_type;

   typedef struct packed {
      logic [3:0]  slot_id;
      logic [15:0] handle_out;
      logic        dispatched;
      logic [1:0]  slot_state;
      logic        error_flag;
      logic [3:0]  occupied_count;
      logic        last_result;
   } rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_SCAN,
      BK_EMIT,
      BK_DONE
   } back_state_type;

endpackage

// ===== design/tts_cmd_queue.sv =====
// Two-entry command queue between the front and the back of the scheduler.
module tts_cmd_queue
   import tts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_word,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_word
);

   cmd_type    mem_ff [2];
   cmd_type    mem_in [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_word   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      mem_in    = mem_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         mem_in[wr_ptr_ff] = push_word;
         wr_ptr_in         = ~wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== design/tts_divider.sv =====
// Iterative ceiling divider, one quotient bit per cycle.
module tts_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [31:0] ticks
);

   logic [31:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] div_ff, div_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [16:0] shifted;
   logic        ge;

   assign shifted = {rem_ff[15:0], quo_ff[31]};
   assign ge      = (shifted >= {1'b0, div_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = (divisor == 16'd0) ? 16'd1 : divisor;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? (shifted - {1'b0, div_ff}) : shifted;
         quo_in  = {quo_ff[30:0], ge};
         cnt_in  = cnt_ff - 6'd1;
         busy_in = (cnt_ff != 6'd1);
      end
   end

   assign done  = !busy_ff && (cnt_ff == 6'd0);
   assign ticks = ((rem_ff != 17'd0) || (quo_ff == 32'd0)) ? quo_ff + 32'd1 : quo_ff;

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      if (reset) begin
         cnt_ff  <= 6'd0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// ===== design/tts_back.sv =====
// Back end: slot table, command execution, dispatch scan and result register.
module tts_back
   import tts_pkg::*;
#(
   parameter int NUM_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] tick_ms,
   input  logic        enable,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_word
);

   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);

   status_type     status_ff [NUM_SLOTS];
   status_type     status_in [NUM_SLOTS];
   logic [31:0]    count_ff [NUM_SLOTS];
   logic [31:0]    count_in [NUM_SLOTS];
   logic [31:0]    reload_ff [NUM_SLOTS];
   logic [31:0]    reload_in [NUM_SLOTS];
   logic [15:0]    handle_ff [NUM_SLOTS];
   logic [15:0]    handle_in [NUM_SLOTS];
   back_state_type state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [IW:0]    idx_ff, idx_in;
   logic [3:0]     nemit_ff, nemit_in;
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_ff, out_in;
   logic           div_start, div_done;
   logic [31:0]    div_ticks;
   logic [CW-1:0]  occ;
   logic           free_found;
   logic [IW-1:0]  free_idx;
   logic           id_ok;
   logic [IW-1:0]  id_idx;
   logic [IW-1:0]  cur;
   logic           cur_ready;
   logic           out_free;
   logic           more_ready;

   tts_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cmd_word.period_ms),
      .divisor  (tick_ms),
      .done     (div_done),
      .ticks    (div_ticks)
   );

   always_comb begin
      occ        = '0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (status_ff[i] != ST_EMPTY) begin
            occ = occ + CW'(1);
         end else if (!free_found) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
      end
   end

   always_comb begin
      more_ready = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if ((IW+1)'(i) > idx_ff && status_ff[i] == ST_RUNNABLE
             && count_ff[i] == 32'd0) begin
            more_ready = 1'b1;
         end
      end
   end

   assign id_ok  = (cmd_ff.task_id >= 8'd1) && ({24'd0, cmd_ff.task_id} <= 32'(NUM_SLOTS))
                   && (status_ff[IW'(cmd_ff.task_id - 8'd1)] != ST_EMPTY);
   assign id_idx = IW'(cmd_ff.task_id - 8'd1);
   assign cur    = idx_ff[IW-1:0];
   assign cur_ready = (status_ff[cur] == ST_RUNNABLE) && (count_ff[cur] == 32'd0);
   assign out_free  = !out_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == BK_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   always_comb begin
      unique case (state_ff)
         BK_IDLE: begin
            state_in = cmd_valid ? ((cmd_word.mode == MODE_ADD) ? BK_DIV :
                       (cmd_word.mode == MODE_DISPATCH && enable) ? BK_SCAN : BK_DONE) : BK_IDLE;
         end
         BK_DIV:  state_in = div_done ? BK_DONE : BK_DIV;
         BK_SCAN: begin
            if (idx_ff == (IW+1)'(NUM_SLOTS) || nemit_ff == 4'(MAX_OUT)) begin
               state_in = BK_DONE;
            end else begin
               state_in = cur_ready ? BK_EMIT : BK_SCAN;
            end
         end
         BK_EMIT: state_in = out_free ? BK_SCAN : BK_EMIT;
         BK_DONE: begin
            if (!out_free) begin
               state_in = BK_DONE;
            end else if (cmd_ff.mode == MODE_DISPATCH && nemit_ff != 4'd0) begin
               state_in = BK_IDLE;
            end else begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      status_in    = status_ff;
      count_in     = count_ff;
      reload_in    = reload_ff;
      handle_in    = handle_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      nemit_in     = nemit_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      div_start    = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_in   = cmd_word;
               idx_in   = '0;
               nemit_in = '0;
               div_start = 1'b0;
            end
         end
         BK_DIV: begin
         end
         BK_SCAN: begin
         end
         BK_EMIT: begin
            if (out_free) begin
               count_in[cur] = reload_ff[cur];
               out_in        = '0;
               out_in.slot_id    = 4'(idx_ff + (IW+1)'(1));
               out_in.handle_out = handle_ff[cur];
               out_in.dispatched = 1'b1;
               out_in.occupied_count = 4'(occ);
               out_in.last_result = !more_ready || (nemit_ff == 4'(MAX_OUT - 1));
               out_valid_in  = 1'b1;
               nemit_in      = nemit_ff + 4'd1;
               idx_in        = idx_ff + (IW+1)'(1);
            end
         end
         BK_DONE: begin
            if (out_free) begin
               out_in = '0;
               out_in.last_result = 1'b1;
               out_valid_in = 1'b1;
               case (cmd_ff.mode)
                  MODE_TICK: begin
                     if (enable) begin
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                           if (status_ff[i] == ST_RUNNABLE && count_ff[i] != 32'd0) begin
                              count_in[i] = count_ff[i] - 32'd1;
                           end
                        end
                     end
                     out_in.occupied_count = 4'(occ);
                  end
                  MODE_DISPATCH: begin
                     out_in.occupied_count = 4'(occ);
                     if (nemit_ff != 4'd0) begin
                        out_in       = out_ff;
                        out_valid_in = 1'b0;
                     end
                  end
                  MODE_ADD: begin
                     if (free_found) begin
                        status_in[free_idx] = ST_RUNNABLE;
                        handle_in[free_idx] = cmd_ff.task_handle;
                        count_in[free_idx]  = div_ticks;
                        reload_in[free_idx] = div_ticks;
                        out_in.slot_id = 4'(free_idx) + 4'd1;
                        out_in.occupied_count = 4'(occ + CW'(1));
                     end else begin
                        out_in.error_flag = 1'b1;
                        out_in.occupied_count = 4'(occ);
                     end
                  end
                  MODE_DELETE, MODE_STOP, MODE_RESUME: begin
                     out_in.error_flag = !id_ok;
                     out_in.occupied_count = 4'(occ);
                     if (id_ok) begin
                        if (cmd_ff.mode == MODE_DELETE) begin
                           status_in[id_idx] = ST_EMPTY;
                           handle_in[id_idx] = '0;
                           out_in.occupied_count = 4'(occ - CW'(1));
                        end else if (cmd_ff.mode == MODE_STOP) begin
                           status_in[id_idx] = ST_STOPPED;
                        end else begin
                           status_in[id_idx] = ST_RUNNABLE;
                        end
                     end
                  end
                  MODE_STATUS: begin
                     out_in.error_flag = !id_ok;
                     out_in.slot_state = id_ok ? status_ff[id_idx] : ST_UNKNOWN;
                     out_in.occupied_count = 4'(occ);
                  end
                  default: begin
                     out_in.occupied_count = 4'(occ);
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
      if (state_ff == BK_IDLE && cmd_valid && cmd_word.mode == MODE_ADD) begin
         div_start = 1'b1;
      end
      if (state_ff == BK_SCAN && !(idx_ff == (IW+1)'(NUM_SLOTS) || nemit_ff == 4'(MAX_OUT))
          && !cur_ready) begin
         idx_in = idx_ff + (IW+1)'(1);
      end
   end

   // A dispatched word is last if no later slot is ready or it is word MAX_OUT.
   always_ff @(posedge clock) begin
      reload_ff <= reload_in;
      handle_ff <= handle_in;
      cmd_ff    <= cmd_in;
      idx_ff    <= idx_in;
      nemit_ff  <= nemit_in;
      out_ff    <= out_in;
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            status_ff[i] <= ST_EMPTY;
            count_ff[i]  <= '0;
         end
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         status_ff    <= status_in;
         count_ff     <= count_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== design/tick_task_scheduler_unit.sv =====
// Top level of the tick task scheduler: register port, front queue and back end.
// Usage:
// Commands enter on the req_ channel (valid/ready) as one word each: mode, task_id,
// period_ms and task_handle. Results leave on the rsp_ channel, one word per command,
// or one word per dispatched task for a dispatch, with rsp_last_result on the final one.
// tick_ms and the enable bit are written over the APB port at byte addresses 0 and 4.
// The user must write them only while the block is idle; it does not enforce this.
// A two-entry queue decouples command acceptance from execution.
// Add commands run the 32-step ceiling divider before they take a slot. The table
// scan visits the slots in order and stops on each ready slot to emit its word.
// Reset empties every slot, sets tick_ms to 1 and disables ticking.
// When the receiver stalls the result register holds and the back end waits;
// the queue keeps accepting until it is full.
module tick_task_scheduler_unit
   import tts_pkg::*;
#(
   parameter int NUM_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_task_id,
   input  logic [31:0] req_period_ms,
   input  logic [15:0] req_task_handle,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_slot_id,
   output logic [15:0] rsp_handle_out,
   output logic        rsp_dispatched,
   output logic [1:0]  rsp_slot_state,
   output logic        rsp_error_flag,
   output logic [3:0]  rsp_occupied_count,
   output logic        rsp_last_result,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [15:0] tick_ms_ff;
   logic        enable_ff;
   cmd_type     req_word, q_word;
   logic        q_valid, q_ready;
   rsp_type     out_word;

   assign pready = 1'b1;
   always_comb begin
      case (paddr[2:2])
         REG_TICK_MS[0]: prdata = {16'd0, tick_ms_ff};
         default:        prdata = {31'd0, enable_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ms_ff <= 16'd1;
         enable_ff  <= 1'b0;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == REG_TICK_MS[0]) begin
            tick_ms_ff <= pwdata[15:0];
         end else if (paddr[2] == REG_ENABLE[0]) begin
            enable_ff <= pwdata[0];
         end
      end
   end

   assign req_word = '{mode: mode_type'(req_mode), task_id: req_task_id,
                       period_ms: req_period_ms, task_handle: req_task_handle};

   tts_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_word  (req_word),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_word   (q_word)
   );

   tts_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .tick_ms   (tick_ms_ff),
      .enable    (enable_ff),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd_word  (q_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (out_word)
   );

   assign rsp_slot_id        = out_word.slot_id;
   assign rsp_handle_out     = out_word.handle_out;
   assign rsp_dispatched     = out_word.dispatched;
   assign rsp_slot_state     = out_word.slot_state;
   assign rsp_error_flag     = out_word.error_flag;
   assign rsp_occupied_count = out_word.occupied_count;
   assign rsp_last_result    = out_word.last_result;

endmodule

// ===== tb/tick_task_scheduler_unit_test.sv =====
// Testbench of the tick task scheduler: directed and random commands checked against a predictor.
`timescale 1ns / 100ps

class slot_table_scoreboard;
   tts_pkg::status_type slot_status[8];
   logic [31:0] slot_countdown[8];
   logic [31:0] slot_reload[8];
   logic [15:0] slot_handle[8];
   logic [15:0] tick_ms;
   logic        enabled;
   tts_pkg::rsp_type expected_words[$];
   int errors;
   int words_checked;
   int dispatch_hits;

   function new();
      for (int i = 0; i < 8; i++) begin
         slot_status[i] = tts_pkg::ST_EMPTY;
         slot_countdown[i] = 0;
         slot_reload[i] = 0;
         slot_handle[i] = 0;
      end
      tick_ms = 1;
      enabled = 0;
      errors = 0;
      words_checked = 0;
      dispatch_hits = 0;
   endfunction

   function logic [3:0] occupied();
      logic [3:0] n;
      n = 0;
      for (int i = 0; i < 8; i++)
         if (slot_status[i] != tts_pkg::ST_EMPTY) n++;
      return n;
   endfunction

   function void push_word(logic [3:0] sid, logic [15:0] h, logic d, logic [1:0] st,
                           logic err, logic last);
      tts_pkg::rsp_type w;
      w.slot_id = sid;
      w.handle_out = h;
      w.dispatched = d;
      w.slot_state = st;
      w.error_flag = err;
      w.occupied_count = occupied();
      w.last_result = last;
      expected_words.push_back(w);
   endfunction

   function void note_command(tts_pkg::mode_type mode, logic [7:0] id, logic [31:0] period,
                              logic [15:0] handle);
      int k;
      int s;
      logic [32:0] div;
      logic [32:0] ticks;
      s = (id >= 1 && id <= 8) ? id - 1 : -1;
      if (s >= 0 && slot_status[s] == tts_pkg::ST_EMPTY) s = -1;
      case (mode)
         tts_pkg::MODE_TICK: begin
            if (enabled)
               for (int i = 0; i < 8; i++)
                  if (slot_status[i] == tts_pkg::ST_RUNNABLE && slot_countdown[i] > 0)
                     slot_countdown[i]--;
            push_word(0, 0, 0, 0, 0, 1);
         end
         tts_pkg::MODE_DISPATCH: begin
            k = 0;
            if (enabled)
               for (int i = 0; i < 8; i++)
                  if (slot_status[i] == tts_pkg::ST_RUNNABLE && slot_countdown[i] == 0) begin
                     slot_countdown[i] = slot_reload[i];
                     push_word(i + 1, slot_handle[i], 1, 0, 0, 0);
                     k++;
                  end
            if (k == 0) push_word(0, 0, 0, 0, 0, 1);
            else begin
               expected_words[$].last_result = 1;
               dispatch_hits += k;
            end
         end
         tts_pkg::MODE_ADD: begin
            div = (tick_ms == 0) ? 1 : tick_ms;
            ticks = ({1'b0, period} + div - 1) / div;
            if (ticks < 1) ticks = 1;
            k = -1;
            for (int i = 0; i < 8; i++)
               if (k < 0 && slot_status[i] == tts_pkg::ST_EMPTY) k = i;
            if (k >= 0) begin
               slot_status[k] = tts_pkg::ST_RUNNABLE;
               slot_handle[k] = handle;
               slot_countdown[k] = ticks[31:0];
               slot_reload[k] = ticks[31:0];
               push_word(k + 1, 0, 0, 0, 0, 1);
            end else push_word(0, 0, 0, 0, 1, 1);
         end
         tts_pkg::MODE_DELETE, tts_pkg::MODE_STOP, tts_pkg::MODE_RESUME: begin
            if (s >= 0) begin
               if (mode == tts_pkg::MODE_DELETE) begin
                  slot_status[s] = tts_pkg::ST_EMPTY;
                  slot_handle[s] = 0;
               end else if (mode == tts_pkg::MODE_STOP) slot_status[s] = tts_pkg::ST_STOPPED;
               else slot_status[s] = tts_pkg::ST_RUNNABLE;
            end
            push_word(0, 0, 0, 0, s < 0, 1);
         end
         tts_pkg::MODE_STATUS:
            push_word(0, 0, 0, s < 0 ? tts_pkg::ST_UNKNOWN : slot_status[s], s < 0, 1);
         default: push_word(0, 0, 0, 0, 0, 1);
      endcase
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   task check_word(tts_pkg::rsp_type got);
      tts_pkg::rsp_type w;
      words_checked++;
      if (expected_words.size() == 0) begin
         report("unexpected word", 0, 0);
         return;
      end
      w = expected_words.pop_front();
      if (got.slot_id !== w.slot_id) report("slot_id", got.slot_id, w.slot_id);
      if (got.handle_out !== w.handle_out) report("handle_out", got.handle_out, w.handle_out);
      if (got.dispatched !== w.dispatched) report("dispatched", got.dispatched, w.dispatched);
      if (got.slot_state !== w.slot_state) report("slot_state", got.slot_state, w.slot_state);
      if (got.error_flag !== w.error_flag) report("error_flag", got.error_flag, w.error_flag);
      if (got.occupied_count !== w.occupied_count)
         report("occupied_count", got.occupied_count, w.occupied_count);
      if (got.last_result !== w.last_result)
         report("last_result", got.last_result, w.last_result);
   endtask
endclass

module tick_task_scheduler_unit_test;
   import tts_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [2:0]  req_mode = 0;
   logic [7:0]  req_task_id = 0;
   logic [31:0] req_period_ms = 0;
   logic [15:0] req_task_handle = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [3:0]  rsp_slot_id;
   logic [15:0] rsp_handle_out;
   logic        rsp_dispatched;
   logic [1:0]  rsp_slot_state;
   logic        rsp_error_flag;
   logic [3:0]  rsp_occupied_count;
   logic        rsp_last_result;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [2:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;

   slot_table_scoreboard board = new();
   int  idle_cycles = 0;
   int  commands_sent = 0;
   int  mode_hits[8];

   tick_task_scheduler_unit i_dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   function int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   always @(posedge clock) begin
      tts_pkg::rsp_type w;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            w.slot_id = rsp_slot_id;
            w.handle_out = rsp_handle_out;
            w.dispatched = rsp_dispatched;
            w.slot_state = rsp_slot_state;
            w.error_flag = rsp_error_flag;
            w.occupied_count = rsp_occupied_count;
            w.last_result = rsp_last_result;
            board.check_word(w);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int stall;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            stall--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
            if (rsp_valid && rsp_ready) stall = gap_length();
         end
      end
   end

   always @(posedge clock)
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d words outstanding.", board.expected_words.size());
         $display("DONE: errors detected");
         $finish;
      end

   task send_command(mode_type mode, logic [7:0] id, logic [31:0] period, logic [15:0] handle);
      int gap;
      req_valid <= 1;
      req_mode <= mode;
      req_task_id <= id;
      req_period_ms <= period;
      req_task_handle <= handle;
      do @(posedge clock); while (!(req_valid && req_ready));
      board.note_command(mode, id, period, handle);
      commands_sent++;
      mode_hits[mode]++;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task write_register(logic [1:0] index, logic [31:0] value);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {index[0], 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      if (index == REG_TICK_MS) board.tick_ms = value[15:0];
      else board.enabled = value[0];
      @(posedge clock);
   endtask

   task drain();
      req_valid <= 0;
      while (board.expected_words.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   function logic [7:0] random_id();
      return ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 9));
   endfunction

   function logic [31:0] random_period();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 3);
         1: return $urandom();
         default: return $urandom_range(0, 40);
      endcase
   endfunction

   task random_phase(int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 30) send_command(MODE_TICK, random_id(), $urandom(), $urandom());
         else if (r < 55) send_command(MODE_DISPATCH, random_id(), $urandom(), $urandom());
         else if (r < 70) send_command(MODE_ADD, random_id(), random_period(), $urandom());
         else send_command(mode_type'($urandom_range(3, 7)), random_id(), $urandom(),
                           $urandom());
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: disabled freeze, full table, extremes, bad ids.
      send_command(MODE_DISPATCH, 0, 0, 0);
      send_command(MODE_STATUS, 1, 0, 0);
      send_command(MODE_DELETE, 0, 0, 0);
      send_command(MODE_ADD, 0, 0, 16'hFFFF);
      send_command(MODE_ADD, 8'hFF, 32'hFFFF_FFFF, 16'h0000);
      drain();
      write_register(REG_TICK_MS, 0);
      write_register(REG_ENABLE, 1);
      for (int i = 0; i < 7; i++) send_command(MODE_ADD, 0, i, 16'hA5A0 + i);
      send_command(MODE_COUNT, 0, 0, 0);
      send_command(MODE_STOP, 2, 0, 0);
      send_command(MODE_STATUS, 2, 0, 0);
      send_command(MODE_TICK, 0, 0, 0);
      send_command(MODE_DISPATCH, 0, 0, 0);
      send_command(MODE_RESUME, 2, 0, 0);
      send_command(MODE_STATUS, 9, 0, 0);
      send_command(MODE_STATUS, 8'hFF, 0, 0);
      send_command(MODE_DELETE, 4, 0, 0);
      send_command(MODE_RESUME, 4, 0, 0);
      drain();

      write_register(REG_TICK_MS, 16'hFFFF);
      send_command(MODE_ADD, 0, 32'hFFFF_FFFF, 16'h1234);
      send_command(MODE_ADD, 0, 1, 16'h4321);
      drain();
      write_register(REG_TICK_MS, 3);
      random_phase(80);
      drain();
      write_register(REG_ENABLE, 0);
      random_phase(30);
      drain();
      write_register(REG_ENABLE, 1);
      write_register(REG_TICK_MS, 1);
      random_phase(80);
      drain();
      write_register(REG_TICK_MS, 10);
      random_phase(50);
      drain();

      $display("Sent %0d commands (ticks %0d, dispatches %0d, adds %0d); checked %0d words,",
               commands_sent, mode_hits[MODE_TICK], mode_hits[MODE_DISPATCH],
               mode_hits[MODE_ADD], board.words_checked);
      $display("with %0d task dispatches across several tick_ms and enable settings.",
               board.dispatch_hits);
      if (board.errors == 0 && board.expected_words.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
